[rtl/spq_pkg.sv]
// Package for the sorted priority queue: command and flag types, opcodes,
// status codes and fixed field widths.
// No dependencies.
`default_nettype none

package spq_pkg;

	// Fixed field widths of the item ports
	localparam int VALUE_W     = 32;
	localparam int PRIO_PORT_W = 8;
	localparam int STATUS_W    = 2;

	// Opcodes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Registered command that drives the slot array
	typedef struct packed {
		logic valid;
		logic op;
	} spq_cmd_t;

	// Occupancy flags of the slot array before the current command
	typedef struct packed {
		logic empty;
		logic full;
	} spq_flags_t;

endpackage : spq_pkg

`default_nettype wire

[rtl/sorted_priority_queue.sv]
// Top level of the sorted priority queue: input register, slot array and
// result register. Depends on spq_pkg and spq_slot_array.
//
// Usage: the queue takes one push or pop item in every clock cycle (busy is
// never raised) and answers each item with exactly one result, marked by done:
// the item passes the input register, where the parallel compare and shift
// over all DEPTH slots updates the queue, and then the result register. The
// receiver cannot stall; each result is shown for a single cycle. Lower
// priority numbers leave first, equal priorities leave in arrival order, and
// only the low PRIORITY_BITS bits of entry_priority are kept.
`default_nettype none

module sorted_priority_queue #(
	parameter int DEPTH         = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	output logic                                  busy,
	input  wire                                   opcode,
	input  wire logic signed [spq_pkg::VALUE_W-1:0] entry_value,
	input  wire logic [spq_pkg::PRIO_PORT_W-1:0]  entry_priority,
	output logic                                  done,
	output logic signed [spq_pkg::VALUE_W-1:0]    popped_value,
	output logic [spq_pkg::PRIO_PORT_W-1:0]       popped_priority,
	output logic                                  pop_valid,
	output logic [spq_pkg::STATUS_W-1:0]          status,
	output logic [$clog2(DEPTH+1)-1:0]            occupancy,
	output logic                                  is_empty,
	output logic                                  is_full
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (PRIORITY_BITS < PRIO_PORT_W) ? PRIORITY_BITS : PRIO_PORT_W;

	spq_cmd_t           cmd_s1;
	logic [VALUE_W-1:0] value_s1;
	logic [PW-1:0]      pri_s1;

	spq_flags_t         flags;
	logic [VALUE_W-1:0] head_value;
	logic [PW-1:0]      head_pri;
	logic [CW-1:0]      count_next;

	logic               done_q;
	logic [VALUE_W-1:0] popped_value_q;
	logic [PW-1:0]      popped_pri_q;
	logic               pop_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [CW-1:0]      occupancy_q;

	logic               pop_hit;

	// Take an item in every cycle
	assign busy = 1'b0;

	// Register the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else begin
			cmd_s1.valid <= start && !busy;
			cmd_s1.op    <= opcode;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			value_s1 <= entry_value;
			pri_s1   <= entry_priority[PW-1:0];
		end
	end

	spq_slot_array #(
		.DEPTH (DEPTH),
		.PW    (PW),
		.CW    (CW)
	) u_slots (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_s1),
		.value      (value_s1),
		.pri        (pri_s1),
		.flags      (flags),
		.head_value (head_value),
		.head_pri   (head_pri),
		.count_next (count_next)
	);

	assign pop_hit = (cmd_s1.op == OP_POP) && !flags.empty;

	// Capture the result of the item in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_s1.valid) begin
			popped_value_q <= pop_hit ? head_value : '0;
			popped_pri_q   <= pop_hit ? head_pri : '0;
			pop_valid_q    <= pop_hit;
			occupancy_q    <= count_next;
			if ((cmd_s1.op == OP_PUSH) && flags.full) begin
				status_q <= ST_FULL;
			end else if ((cmd_s1.op == OP_POP) && flags.empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
		end
	end

	// Drive the result ports
	assign done            = done_q;
	assign popped_value    = popped_value_q;
	assign popped_priority = PRIO_PORT_W'(popped_pri_q);
	assign pop_valid       = pop_valid_q;
	assign status          = status_q;
	assign occupancy       = occupancy_q;
	assign is_empty        = (occupancy_q == '0);
	assign is_full         = (occupancy_q == CW'(DEPTH));

	// Every registered item yields a result in the next cycle
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_s1.valid |=> done_q)
		else $error("item in input register gave no result");

	// A successful pop always reports ok
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && pop_valid_q) |-> (status_q == ST_OK))
		else $error("pop with data reported an error status");

	// A dropped push leaves the queue full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == ST_FULL)) |-> (occupancy_q == CW'(DEPTH)))
		else $error("push dropped while queue not full");

	// Occupancy never exceeds the depth
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (occupancy_q <= CW'(DEPTH)))
		else $error("occupancy above depth");

endmodule : sorted_priority_queue

`default_nettype wire

[rtl/spq_slot_array.sv]
// Slot array of the sorted priority queue: DEPTH registered slots with a
// parallel priority compare, sorted insert on push and shift to head on pop.
// Depends on spq_pkg.
`default_nettype none

module spq_slot_array #(
	parameter int DEPTH = 16,
	parameter int PW    = 8,
	parameter int CW    = 5
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  spq_pkg::spq_cmd_t               cmd,
	input  wire logic [spq_pkg::VALUE_W-1:0] value,
	input  wire logic [PW-1:0]              pri,
	output spq_pkg::spq_flags_t             flags,
	output logic [spq_pkg::VALUE_W-1:0]     head_value,
	output logic [PW-1:0]                   head_pri,
	output logic [CW-1:0]                   count_next
);
	import spq_pkg::*;

	logic [VALUE_W-1:0] slot_value_q [DEPTH];
	logic [PW-1:0]      slot_pri_q   [DEPTH];
	logic [CW-1:0]      count_q;
	logic [DEPTH-1:0]   keep;
	logic               push_ok;
	logic               pop_ok;

	// Flag the current fill level
	assign flags.empty = (count_q == '0);
	assign flags.full  = (count_q == CW'(DEPTH));

	assign push_ok = cmd.valid && (cmd.op == OP_PUSH) && !flags.full;
	assign pop_ok  = cmd.valid && (cmd.op == OP_POP) && !flags.empty;

	// Mark live slots that stay ahead of the new entry (equal priority stays ahead)
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			keep[i] = (CW'(i) < count_q) && (slot_pri_q[i] <= pri);
		end
	end

	assign head_value = slot_value_q[0];
	assign head_pri   = slot_pri_q[0];

	// Advance the entry count
	always_comb begin
		count_next = count_q;
		if (push_ok) begin
			count_next = count_q + CW'(1);
		end else if (pop_ok) begin
			count_next = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// Per slot: hold, take the new entry, shift back for insert, or shift to head on pop
	for (genvar g = 0; g < DEPTH; g++) begin : g_slot
		always_ff @(posedge clk) begin
			if (push_ok && !keep[g]) begin
				if (g == 0) begin
					slot_value_q[g] <= value;
					slot_pri_q[g]   <= pri;
				end else if (keep[(g > 0) ? g - 1 : 0]) begin
					slot_value_q[g] <= value;
					slot_pri_q[g]   <= pri;
				end else begin
					slot_value_q[g] <= slot_value_q[(g > 0) ? g - 1 : 0];
					slot_pri_q[g]   <= slot_pri_q[(g > 0) ? g - 1 : 0];
				end
			end else if (pop_ok && (g < DEPTH - 1)) begin
				slot_value_q[g] <= slot_value_q[(g < DEPTH - 1) ? g + 1 : g];
				slot_pri_q[g]   <= slot_pri_q[(g < DEPTH - 1) ? g + 1 : g];
			end
		end
	end

endmodule : spq_slot_array

`default_nettype wire

[tb/spq_checker.sv]
// Checker for the sorted priority queue: watches the item and result ports,
// predicts each result with its own copy of the queue and compares field by field.
// Depends on spq_pkg for the opcode and status codes and the port widths.

module spq_checker #(
	parameter int DEPTH         = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    start,
	input  wire                                    busy,
	input  wire                                    opcode,
	input  wire logic signed [spq_pkg::VALUE_W-1:0] entry_value,
	input  wire logic [spq_pkg::PRIO_PORT_W-1:0]   entry_priority,
	input  wire                                    done,
	input  wire logic signed [spq_pkg::VALUE_W-1:0] popped_value,
	input  wire logic [spq_pkg::PRIO_PORT_W-1:0]   popped_priority,
	input  wire                                    pop_valid,
	input  wire logic [spq_pkg::STATUS_W-1:0]      status,
	input  wire logic [$clog2(DEPTH+1)-1:0]        occupancy,
	input  wire                                    is_empty,
	input  wire                                    is_full,
	output int                                     mismatches,
	output int                                     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int OCC_W = $clog2(DEPTH+1);
	localparam logic [PRIO_PORT_W-1:0] PRIO_MASK =
		(PRIORITY_BITS >= PRIO_PORT_W) ? '1 : PRIO_PORT_W'((1 << PRIORITY_BITS) - 1);

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [PRIO_PORT_W-1:0]    prio;
		logic                      valid;
		logic [STATUS_W-1:0]       stat;
		logic [OCC_W-1:0]          occ;
		logic                      empty;
		logic                      full;
	} queue_outcome_t;

	// Predicted contents of the queue, slot 0 is the head
	logic signed [VALUE_W-1:0] held_values [DEPTH];
	logic [PRIO_PORT_W-1:0]    held_prios [DEPTH];
	int                        held_count = 0;

	queue_outcome_t awaited_outcomes [$];

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	// Apply one push or pop to the predicted queue and return its outcome
	function automatic queue_outcome_t apply_queue_op(logic op, logic signed [VALUE_W-1:0] val,
			logic [PRIO_PORT_W-1:0] pri);
		queue_outcome_t r;
		logic [PRIO_PORT_W-1:0] kept_pri;
		int slot;
		r = '0;
		r.stat = ST_OK;
		kept_pri = pri & PRIO_MASK;
		if (op == OP_PUSH) begin
			if (held_count >= DEPTH) begin
				r.stat = ST_FULL;
			end else begin
				// insert behind every entry of lower or equal priority
				slot = 0;
				while (slot < held_count && held_prios[slot] <= kept_pri)
					slot++;
				for (int i = held_count; i > slot; i--) begin
					held_values[i] = held_values[i-1];
					held_prios[i]  = held_prios[i-1];
				end
				held_values[slot] = val;
				held_prios[slot]  = kept_pri;
				held_count++;
			end
		end else if (held_count == 0) begin
			r.stat = ST_EMPTY;
		end else begin
			r.value = held_values[0];
			r.prio  = held_prios[0];
			r.valid = 1'b1;
			for (int i = 1; i < held_count; i++) begin
				held_values[i-1] = held_values[i];
				held_prios[i-1]  = held_prios[i];
			end
			held_count--;
		end
		r.occ   = OCC_W'(held_count);
		r.empty = (held_count == 0);
		r.full  = (held_count == DEPTH);
		return r;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Compare each result with the oldest prediction, then predict the new item
	always @(posedge clk) begin
		queue_outcome_t want;
		if (!arst_n) begin
			held_count = 0;
			awaited_outcomes.delete();
		end else begin
			if (done) begin
				if (awaited_outcomes.size() == 0) begin
					$error("result with no item outstanding");
					mismatches++;
				end else begin
					want = awaited_outcomes.pop_front();
					check_field("popped_value", want.value, popped_value);
					check_field("popped_priority", want.prio, popped_priority);
					check_field("pop_valid", want.valid, pop_valid);
					check_field("status", want.stat, status);
					check_field("occupancy", want.occ, occupancy);
					check_field("is_empty", want.empty, is_empty);
					check_field("is_full", want.full, is_full);
				end
			end
			if (start && !busy)
				awaited_outcomes.push_back(apply_queue_op(opcode, entry_value, entry_priority));
		end
		outstanding = awaited_outcomes.size();
	end

endmodule

[tb/tb_sorted_priority_queue.sv]
// Top of the sorted priority queue testbench: clock, reset and item stimulus.
// Depends on spq_pkg, sorted_priority_queue and spq_checker, which does the checking.

module tb_sorted_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int DEPTH         = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int RANDOM_ITEMS  = 650;
	localparam int CALM_TAIL     = 100;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic                      opcode = OP_PUSH;
	logic signed [VALUE_W-1:0] entry_value = '0;
	logic [PRIO_PORT_W-1:0]    entry_priority = '0;
	logic                      done;
	logic signed [VALUE_W-1:0] popped_value;
	logic [PRIO_PORT_W-1:0]    popped_priority;
	logic                      pop_valid;
	logic [STATUS_W-1:0]       status;
	logic [$clog2(DEPTH+1)-1:0] occupancy;
	logic                      is_empty;
	logic                      is_full;
	int                        mismatches;
	int                        outstanding;

	always #5 clk = ~clk;

	sorted_priority_queue #(
		.DEPTH(DEPTH),
		.PRIORITY_BITS(PRIORITY_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.entry_value(entry_value),
		.entry_priority(entry_priority),
		.done(done),
		.popped_value(popped_value),
		.popped_priority(popped_priority),
		.pop_valid(pop_valid),
		.status(status),
		.occupancy(occupancy),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	spq_checker #(
		.DEPTH(DEPTH),
		.PRIORITY_BITS(PRIORITY_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.entry_value(entry_value),
		.entry_priority(entry_priority),
		.done(done),
		.popped_value(popped_value),
		.popped_priority(popped_priority),
		.pop_valid(pop_valid),
		.status(status),
		.occupancy(occupancy),
		.is_empty(is_empty),
		.is_full(is_full),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// Present one item and hold it until the queue takes it
	task automatic send_item(logic op, logic signed [VALUE_W-1:0] val,
			logic [PRIO_PORT_W-1:0] pri);
		@(negedge clk);
		start          <= 1'b1;
		opcode         <= op;
		entry_value    <= val;
		entry_priority <= pri;
		do @(posedge clk); while (busy);
	endtask

	// Drop start for a burst of idle cycles
	task automatic hold_off(int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Stop sending until every outstanding result has come back
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		wait (outstanding == 0);
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Favour a few close priorities so that ties are common
	function automatic logic [PRIO_PORT_W-1:0] pick_priority();
		case ($urandom_range(0, 3))
			0, 1:    return PRIO_PORT_W'($urandom_range(0, 3));
			2:       return PRIO_PORT_W'($urandom_range(0, 255));
			default: return $urandom_range(0, 1) ? '1 : '0;
		endcase
	endfunction

	initial begin
		int sent;
		int run_left;
		int push_pct;
		logic op;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: empty pop, extremes, ties, fill to full, overflow, some pops
		send_item(OP_POP, 32'sh1234_5678, 8'hFF);
		send_item(OP_PUSH, 32'sd7, 8'd5);
		send_item(OP_PUSH, 32'sh7fff_ffff, 8'hFF);
		send_item(OP_PUSH, 32'sh8000_0000, 8'h00);
		send_item(OP_PUSH, -32'sd1, 8'd5);
		send_item(OP_PUSH, 32'sd0, 8'd5);
		send_item(OP_PUSH, 32'sd123, 8'h00);
		for (int i = 0; i < DEPTH - 6; i++)
			send_item(OP_PUSH, $urandom, PRIO_PORT_W'(i * 25));
		send_item(OP_PUSH, 32'sh5555_5555, 8'h00);
		repeat (5) send_item(OP_POP, $urandom, PRIO_PORT_W'($urandom_range(0, 255)));

		drain_results();

		// random: runs with a push bias that sweeps the queue from empty to full
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0:       push_pct = 15;
				1:       push_pct = 50;
				default: push_pct = 85;
			endcase
			run_left = $urandom_range(20, 60);
			while (run_left > 0 && sent < RANDOM_ITEMS) begin
				op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
				send_item(op, pick_value(), pick_priority());
				sent++;
				run_left--;
				if (sent < RANDOM_ITEMS - CALM_TAIL) begin
					if ($urandom_range(0, 3) == 0)
						hold_off($urandom_range(1, 5));
					else if ($urandom_range(0, 99) == 0)
						drain_results();
				end
			end
		end

		// wait out the last results, then the pipeline latency
		@(negedge clk);
		start <= 1'b0;
		for (int n = 0; n < 100 && outstanding != 0; n++)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			if (outstanding != 0)
				$error("%0d results never arrived", outstanding);
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#1ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
rtl/spq_pkg.sv
rtl/spq_slot_array.sv
rtl/sorted_priority_queue.sv
tb/spq_checker.sv
tb/tb_sorted_priority_queue.sv
